>>> hdl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared definitions for the ray/triangle intersection pipeline
// Widths, register indexes, stage payload types and the divider step.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int COORD_BITS   = 20;
	localparam int FRAC_BITS    = 12;
	localparam int EPS_BITS     = 12;
	localparam int VERT_BITS    = 3 * COORD_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * EDGE_BITS;
	localparam int CROSS_BITS = PROD_BITS + 1 - FRAC_BITS;
	localparam int TERM_BITS  = CROSS_BITS + EDGE_BITS;
	localparam int DOT_BITS   = TERM_BITS + 2;
	localparam int MAG_BITS   = DOT_BITS - 1;

	localparam int DIST_BITS  = 31;
	localparam int BARY_BITS  = FRAC_BITS + 1;
	localparam int T_INT_BITS = DIST_BITS - FRAC_BITS;
	localparam int DIV_STAGES = DIST_BITS;
	localparam int UV_START   = DIST_BITS - BARY_BITS;
	localparam int PT_BITS    = DIST_BITS + 1 + COORD_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_VERTEX_A,
		REG_VERTEX_B,
		REG_VERTEX_C,
		REG_EPSILON
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EDGE_BITS-1:0]  edge_t;

	typedef struct packed {
		logic   miss;
		coord_t ox;
		coord_t oy;
		coord_t oz;
		coord_t dx;
		coord_t dy;
		coord_t dz;
	} ray_tag_t;

	typedef struct packed {
		logic [MAG_BITS-1:0]  det;
		logic [MAG_BITS-1:0]  rem_t;
		logic [MAG_BITS-1:0]  rem_u;
		logic [MAG_BITS-1:0]  rem_v;
		logic [DIST_BITS-1:0] feed_t;
		logic [DIST_BITS-1:0] q_t;
		logic [BARY_BITS-1:0] feed_u;
		logic [BARY_BITS-1:0] feed_v;
		logic [BARY_BITS-1:0] q_u;
		logic [BARY_BITS-1:0] q_v;
		logic                 ovf;
		ray_tag_t             tag;
	} divs_t;

	// One restoring division step; returns {quotient bit, new remainder}.
	function automatic logic [MAG_BITS:0] div_step(input logic [MAG_BITS-1:0] rem,
		input logic b, input logic [MAG_BITS-1:0] den);
		logic [MAG_BITS:0] s;
		logic [MAG_BITS:0] diff;
		s = {rem, b};
		diff = s - {1'b0, den};
		if (s >= {1'b0, den}) begin
			return {1'b1, diff[MAG_BITS-1:0]};
		end
		return {1'b0, s[MAG_BITS-1:0]};
	endfunction

endpackage

>>> hdl/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: edge vectors, cross and dot products, determinant tests
// Seven stages that end in the initial state of the division pipeline.
// ----------------------------------------------------------------------------
module rti_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  rti_pkg::coord_t                    ox,
	input  rti_pkg::coord_t                    oy,
	input  rti_pkg::coord_t                    oz,
	input  rti_pkg::coord_t                    dx,
	input  rti_pkg::coord_t                    dy,
	input  rti_pkg::coord_t                    dz,
	input  logic [rti_pkg::VERT_BITS-1:0]      vertex_a,
	input  logic [rti_pkg::VERT_BITS-1:0]      vertex_b,
	input  logic [rti_pkg::VERT_BITS-1:0]      vertex_c,
	input  logic [rti_pkg::EPS_BITS-1:0]       epsilon,
	output logic                               out_valid,
	output rti_pkg::divs_t                     out_data
);

	rti_pkg::coord_t va [3];
	rti_pkg::coord_t vb [3];
	rti_pkg::coord_t vc [3];
	rti_pkg::coord_t o_in [3];
	rti_pkg::coord_t d_in [3];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	rti_pkg::coord_t o_s1 [3];
	rti_pkg::edge_t  d_s1 [3];
	rti_pkg::edge_t  e1_s1 [3];
	rti_pkg::edge_t  e2_s1 [3];
	rti_pkg::edge_t  tv_s1 [3];

	rti_pkg::coord_t o_s2 [3];
	rti_pkg::edge_t  d_s2 [3];
	rti_pkg::edge_t  e1_s2 [3];
	rti_pkg::edge_t  e2_s2 [3];
	rti_pkg::edge_t  tv_s2 [3];
	logic signed [rti_pkg::PROD_BITS-1:0] pa_s2 [3];
	logic signed [rti_pkg::PROD_BITS-1:0] pb_s2 [3];
	logic signed [rti_pkg::PROD_BITS-1:0] qa_s2 [3];
	logic signed [rti_pkg::PROD_BITS-1:0] qb_s2 [3];

	rti_pkg::coord_t o_s3 [3];
	rti_pkg::edge_t  d_s3 [3];
	rti_pkg::edge_t  e1_s3 [3];
	rti_pkg::edge_t  e2_s3 [3];
	rti_pkg::edge_t  tv_s3 [3];
	logic signed [rti_pkg::CROSS_BITS-1:0] p_s3 [3];
	logic signed [rti_pkg::CROSS_BITS-1:0] q_s3 [3];

	rti_pkg::coord_t o_s4 [3];
	rti_pkg::edge_t  d_s4 [3];
	logic signed [rti_pkg::TERM_BITS-1:0] det_s4 [3];
	logic signed [rti_pkg::TERM_BITS-1:0] nt_s4 [3];
	logic signed [rti_pkg::TERM_BITS-1:0] nu_s4 [3];
	logic signed [rti_pkg::TERM_BITS-1:0] nv_s4 [3];

	rti_pkg::coord_t o_s5 [3];
	rti_pkg::edge_t  d_s5 [3];
	logic signed [rti_pkg::DOT_BITS-1:0] det_s5, nt_s5, nu_s5, nv_s5;

	rti_pkg::coord_t o_s6 [3];
	rti_pkg::edge_t  d_s6 [3];
	logic signed [rti_pkg::DOT_BITS-1:0] det_s6, nt_s6, nu_s6, nv_s6;
	logic degen_s6;

	rti_pkg::divs_t div_s7;

	logic signed [rti_pkg::DOT_BITS-1:0] epsw;
	logic signed [rti_pkg::DOT_BITS:0]   uv_sum;
	logic [rti_pkg::MAG_BITS-1:0]        det_m, nt_m, nu_m, nv_m;
	logic                                outside;

	assign o_in[0] = ox;
	assign o_in[1] = oy;
	assign o_in[2] = oz;
	assign d_in[0] = dx;
	assign d_in[1] = dy;
	assign d_in[2] = dz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = vertex_a[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS];
			vb[i] = vertex_b[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS];
			vc[i] = vertex_c[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS];
		end
	end

	always_comb begin
		epsw = '0;
		epsw[rti_pkg::FRAC_BITS +: rti_pkg::EPS_BITS] = epsilon;
		uv_sum = {nu_s6[rti_pkg::DOT_BITS-1], nu_s6} + {nv_s6[rti_pkg::DOT_BITS-1], nv_s6};
		outside = nu_s6[rti_pkg::DOT_BITS-1] || (nu_s6 > det_s6) ||
			nv_s6[rti_pkg::DOT_BITS-1] ||
			(uv_sum > {det_s6[rti_pkg::DOT_BITS-1], det_s6}) ||
			(nt_s6 <= 0);
		det_m = det_s6[rti_pkg::MAG_BITS-1:0];
		nt_m = nt_s6[rti_pkg::MAG_BITS-1:0];
		nu_m = nu_s6[rti_pkg::MAG_BITS-1:0];
		nv_m = nv_s6[rti_pkg::MAG_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				o_s1[i]  <= o_in[i];
				d_s1[i]  <= rti_pkg::edge_t'(d_in[i]);
				e1_s1[i] <= rti_pkg::edge_t'(vb[i]) - rti_pkg::edge_t'(va[i]);
				e2_s1[i] <= rti_pkg::edge_t'(vc[i]) - rti_pkg::edge_t'(va[i]);
				tv_s1[i] <= rti_pkg::edge_t'(o_in[i]) - rti_pkg::edge_t'(va[i]);
			end

			o_s2 <= o_s1;
			d_s2 <= d_s1;
			e1_s2 <= e1_s1;
			e2_s2 <= e2_s1;
			tv_s2 <= tv_s1;
			// P = D x E2 and Q = T x E1, split into the two product halves.
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= d_s1[(i+1)%3] * e2_s1[(i+2)%3];
				pb_s2[i] <= d_s1[(i+2)%3] * e2_s1[(i+1)%3];
				qa_s2[i] <= tv_s1[(i+1)%3] * e1_s1[(i+2)%3];
				qb_s2[i] <= tv_s1[(i+2)%3] * e1_s1[(i+1)%3];
			end

			o_s3 <= o_s2;
			d_s3 <= d_s2;
			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			tv_s3 <= tv_s2;
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= rti_pkg::CROSS_BITS'(
					(rti_pkg::PROD_BITS'(pa_s2[i]) - pb_s2[i]) >>> rti_pkg::FRAC_BITS);
				q_s3[i] <= rti_pkg::CROSS_BITS'(
					(rti_pkg::PROD_BITS'(qa_s2[i]) - qb_s2[i]) >>> rti_pkg::FRAC_BITS);
			end

			o_s4 <= o_s3;
			d_s4 <= d_s3;
			for (int i = 0; i < 3; i++) begin
				det_s4[i] <= p_s3[i] * e1_s3[i];
				nt_s4[i]  <= q_s3[i] * e2_s3[i];
				nu_s4[i]  <= p_s3[i] * tv_s3[i];
				nv_s4[i]  <= q_s3[i] * d_s3[i];
			end

			o_s5 <= o_s4;
			d_s5 <= d_s4;
			det_s5 <= rti_pkg::DOT_BITS'(det_s4[0]) + det_s4[1] + det_s4[2];
			nt_s5  <= rti_pkg::DOT_BITS'(nt_s4[0]) + nt_s4[1] + nt_s4[2];
			nu_s5  <= rti_pkg::DOT_BITS'(nu_s4[0]) + nu_s4[1] + nu_s4[2];
			nv_s5  <= rti_pkg::DOT_BITS'(nv_s4[0]) + nv_s4[1] + nv_s4[2];

			// A negative determinant flips the sign of every numerator too.
			o_s6 <= o_s5;
			d_s6 <= d_s5;
			degen_s6 <= (det_s5 > -epsw) && (det_s5 < epsw);
			if (det_s5[rti_pkg::DOT_BITS-1]) begin
				det_s6 <= -det_s5;
				nt_s6  <= -nt_s5;
				nu_s6  <= -nu_s5;
				nv_s6  <= -nv_s5;
			end else begin
				det_s6 <= det_s5;
				nt_s6  <= nt_s5;
				nu_s6  <= nu_s5;
				nv_s6  <= nv_s5;
			end

			div_s7.det    <= det_m;
			div_s7.rem_t  <= nt_m >> rti_pkg::T_INT_BITS;
			div_s7.feed_t <= {nt_m[rti_pkg::T_INT_BITS-1:0], {rti_pkg::FRAC_BITS{1'b0}}};
			div_s7.ovf    <= (nt_m >> rti_pkg::T_INT_BITS) >= det_m;
			div_s7.q_t    <= '0;
			div_s7.rem_u  <= nu_m >> 1;
			div_s7.feed_u <= {nu_m[0], {rti_pkg::FRAC_BITS{1'b0}}};
			div_s7.q_u    <= '0;
			div_s7.rem_v  <= nv_m >> 1;
			div_s7.feed_v <= {nv_m[0], {rti_pkg::FRAC_BITS{1'b0}}};
			div_s7.q_v    <= '0;
			div_s7.tag.miss <= degen_s6 || outside;
			div_s7.tag.ox <= o_s6[0];
			div_s7.tag.oy <= o_s6[1];
			div_s7.tag.oz <= o_s6[2];
			div_s7.tag.dx <= rti_pkg::COORD_BITS'(d_s6[0]);
			div_s7.tag.dy <= rti_pkg::COORD_BITS'(d_s6[1]);
			div_s7.tag.dz <= rti_pkg::COORD_BITS'(d_s6[2]);
		end
	end

	assign out_valid = valid_s7;
	assign out_data  = div_s7;

endmodule

>>> hdl/rti_divider.sv
// ----------------------------------------------------------------------------
// rti_divider: pipelined restoring division for t, u and v
// One quotient bit per stage; u and v join for the last BARY_BITS stages.
// ----------------------------------------------------------------------------
module rti_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  rti_pkg::divs_t in_data,
	output logic           out_valid,
	output rti_pkg::divs_t out_data
);

	logic           valid_s [rti_pkg::DIV_STAGES+1];
	rti_pkg::divs_t data_s  [rti_pkg::DIV_STAGES+1];

	assign valid_s[0] = in_valid;
	assign data_s[0]  = in_data;

	for (genvar k = 0; k < rti_pkg::DIV_STAGES; k++) begin : g_stage
		rti_pkg::divs_t nxt;
		logic [rti_pkg::MAG_BITS:0] st_t, st_u, st_v;

		always_comb begin
			nxt = data_s[k];
			st_t = rti_pkg::div_step(data_s[k].rem_t, data_s[k].feed_t[rti_pkg::DIST_BITS-1],
				data_s[k].det);
			nxt.rem_t  = st_t[rti_pkg::MAG_BITS-1:0];
			nxt.q_t    = {data_s[k].q_t[rti_pkg::DIST_BITS-2:0], st_t[rti_pkg::MAG_BITS]};
			nxt.feed_t = data_s[k].feed_t << 1;
			st_u = rti_pkg::div_step(data_s[k].rem_u, data_s[k].feed_u[rti_pkg::BARY_BITS-1],
				data_s[k].det);
			st_v = rti_pkg::div_step(data_s[k].rem_v, data_s[k].feed_v[rti_pkg::BARY_BITS-1],
				data_s[k].det);
			if (k >= rti_pkg::UV_START) begin
				nxt.rem_u  = st_u[rti_pkg::MAG_BITS-1:0];
				nxt.q_u    = {data_s[k].q_u[rti_pkg::BARY_BITS-2:0], st_u[rti_pkg::MAG_BITS]};
				nxt.feed_u = data_s[k].feed_u << 1;
				nxt.rem_v  = st_v[rti_pkg::MAG_BITS-1:0];
				nxt.q_v    = {data_s[k].q_v[rti_pkg::BARY_BITS-2:0], st_v[rti_pkg::MAG_BITS]};
				nxt.feed_v = data_s[k].feed_v << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				data_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[rti_pkg::DIV_STAGES];
	assign out_data  = data_s[rti_pkg::DIV_STAGES];

endmodule

>>> hdl/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back: distance saturation, final tests and hit point
// Two stages: t times direction, then add origin, saturate and register.
// ----------------------------------------------------------------------------
module rti_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_valid,
	input  rti_pkg::divs_t                       in_data,
	input  logic [rti_pkg::EPS_BITS-1:0]         epsilon,
	output logic                                 out_valid,
	output logic                                 hit,
	output logic [rti_pkg::DIST_BITS-1:0]        distance,
	output logic [rti_pkg::BARY_BITS-1:0]        bary_u,
	output logic [rti_pkg::BARY_BITS-1:0]        bary_v,
	output rti_pkg::coord_t                      point_x,
	output rti_pkg::coord_t                      point_y,
	output rti_pkg::coord_t                      point_z
);

	localparam logic signed [rti_pkg::PT_BITS-1:0] CMAX =
		rti_pkg::PT_BITS'((64'sd1 <<< (rti_pkg::COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [rti_pkg::PT_BITS-1:0] CMIN =
		rti_pkg::PT_BITS'(-(64'sd1 <<< (rti_pkg::COORD_BITS - 1)));

	logic [rti_pkg::DIST_BITS-1:0]  t_sat;
	logic signed [rti_pkg::DIST_BITS:0] t_sgn;
	rti_pkg::coord_t                d_in [3];

	logic                           valid_s1, valid_s2;
	logic                           miss_s1;
	logic [rti_pkg::DIST_BITS-1:0]  t_s1;
	logic [rti_pkg::BARY_BITS-1:0]  u_s1, v_s1;
	rti_pkg::coord_t                o_s1 [3];
	logic signed [rti_pkg::PT_BITS-1:0] prod_s1 [3];

	logic signed [rti_pkg::PT_BITS-1:0] pt [3];
	rti_pkg::coord_t                    pt_sat [3];

	always_comb begin
		t_sat = in_data.ovf ? {rti_pkg::DIST_BITS{1'b1}} : in_data.q_t;
		t_sgn = {1'b0, t_sat};
		d_in[0] = in_data.tag.dx;
		d_in[1] = in_data.tag.dy;
		d_in[2] = in_data.tag.dz;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt[i] = rti_pkg::PT_BITS'(o_s1[i]) + (prod_s1[i] >>> rti_pkg::FRAC_BITS);
			if (pt[i] > CMAX) begin
				pt_sat[i] = rti_pkg::COORD_BITS'(CMAX);
			end else if (pt[i] < CMIN) begin
				pt_sat[i] = rti_pkg::COORD_BITS'(CMIN);
			end else begin
				pt_sat[i] = rti_pkg::COORD_BITS'(pt[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s1 <= in_data.tag.miss || (t_sat <= rti_pkg::DIST_BITS'(epsilon));
			t_s1    <= t_sat;
			u_s1    <= in_data.q_u;
			v_s1    <= in_data.q_v;
			o_s1[0] <= in_data.tag.ox;
			o_s1[1] <= in_data.tag.oy;
			o_s1[2] <= in_data.tag.oz;
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= t_sgn * d_in[i];
			end

			// A miss reports zero in every field.
			hit      <= !miss_s1;
			distance <= miss_s1 ? '0 : t_s1;
			bary_u   <= miss_s1 ? '0 : u_s1;
			bary_v   <= miss_s1 ? '0 : v_s1;
			point_x  <= miss_s1 ? '0 : pt_sat[0];
			point_y  <= miss_s1 ? '0 : pt_sat[1];
			point_z  <= miss_s1 ? '0 : pt_sat[2];
		end
	end

	assign out_valid = valid_s2;

endmodule

>>> hdl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: fixed-point ray/triangle intersection pipeline
// An accepted ray passes through 7 geometry stages, 31 one-bit division stages
// and 2 output stages on its way to the result. Throughput is one ray per
// cycle; a stalled result freezes the whole pipeline. Reset clears all valid
// bits and returns the vertices to zero and epsilon to one.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [rti_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rti_pkg::VERT_BITS-1:0]      cfg_data,
	input  logic                               ray_valid,
	output logic                               ray_stall,
	input  rti_pkg::coord_t                    origin_x,
	input  rti_pkg::coord_t                    origin_y,
	input  rti_pkg::coord_t                    origin_z,
	input  rti_pkg::coord_t                    direction_x,
	input  rti_pkg::coord_t                    direction_y,
	input  rti_pkg::coord_t                    direction_z,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               hit,
	output logic [rti_pkg::DIST_BITS-1:0]      distance,
	output logic [rti_pkg::BARY_BITS-1:0]      bary_u,
	output logic [rti_pkg::BARY_BITS-1:0]      bary_v,
	output rti_pkg::coord_t                    point_x,
	output rti_pkg::coord_t                    point_y,
	output rti_pkg::coord_t                    point_z
);

	logic [rti_pkg::VERT_BITS-1:0] vertex_a_q, vertex_b_q, vertex_c_q;
	logic [rti_pkg::EPS_BITS-1:0]  epsilon_q;

	logic           adv;
	logic           front_valid, div_valid;
	rti_pkg::divs_t front_data, div_data;

	// The pipeline moves whenever the output register is free or being taken.
	assign adv       = !(result_valid && result_stall);
	assign ray_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_a_q <= '0;
			vertex_b_q <= '0;
			vertex_c_q <= '0;
			epsilon_q  <= rti_pkg::EPS_BITS'(1);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				rti_pkg::REG_VERTEX_A: vertex_a_q <= cfg_data;
				rti_pkg::REG_VERTEX_B: vertex_b_q <= cfg_data;
				rti_pkg::REG_VERTEX_C: vertex_c_q <= cfg_data;
				rti_pkg::REG_EPSILON:  epsilon_q  <= cfg_data[rti_pkg::EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	rti_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (ray_valid),
		.ox       (origin_x),
		.oy       (origin_y),
		.oz       (origin_z),
		.dx       (direction_x),
		.dy       (direction_y),
		.dz       (direction_z),
		.vertex_a (vertex_a_q),
		.vertex_b (vertex_b_q),
		.vertex_c (vertex_c_q),
		.epsilon  (epsilon_q),
		.out_valid(front_valid),
		.out_data (front_data)
	);

	rti_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (front_valid),
		.in_data  (front_data),
		.out_valid(div_valid),
		.out_data (div_data)
	);

	rti_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (div_valid),
		.in_data  (div_data),
		.epsilon  (epsilon_q),
		.out_valid(result_valid),
		.hit      (hit),
		.distance (distance),
		.bary_u   (bary_u),
		.bary_v   (bary_v),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z)
	);

	// A miss transaction carries all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hit |-> distance == '0 && bary_u == '0 && bary_v == '0)
		else $error("miss result with nonzero fields");

	// Barycentric coordinates of a hit stay inside the triangle.
	a_bary_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && hit |->
		({1'b0, bary_u} + {1'b0, bary_v}) <= (rti_pkg::BARY_BITS + 1)'(1 << rti_pkg::FRAC_BITS))
		else $error("hit with barycentric sum above one");

	// A hit always lies beyond the near threshold.
	a_dist_eps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && hit |-> distance > rti_pkg::DIST_BITS'(epsilon_q))
		else $error("hit distance not above epsilon");

endmodule

>>> test/ray_triangle_intersect_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb: self-checking bench for the ray/triangle block
// Rays are streamed against several triangle and threshold settings. Each
// accepted ray is run through a local fixed-point intersection model and the
// results coming out of the block are compared in order, field by field.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;

	typedef struct packed {
		rti_pkg::coord_t ox;
		rti_pkg::coord_t oy;
		rti_pkg::coord_t oz;
		rti_pkg::coord_t dx;
		rti_pkg::coord_t dy;
		rti_pkg::coord_t dz;
	} ray_t;

	typedef struct packed {
		logic                          hit;
		logic [rti_pkg::DIST_BITS-1:0] dist_v;
		logic [rti_pkg::BARY_BITS-1:0] u;
		logic [rti_pkg::BARY_BITS-1:0] v;
		rti_pkg::coord_t               px;
		rti_pkg::coord_t               py;
		rti_pkg::coord_t               pz;
	} isect_t;

	localparam longint ONE      = 64'sd1 << rti_pkg::FRAC_BITS;
	localparam longint DIST_MAX = (64'sd1 << rti_pkg::DIST_BITS) - 1;
	localparam int     LATENCY  = 40;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write_en;
	logic [rti_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [rti_pkg::VERT_BITS-1:0]    cfg_data;
	logic                             ray_valid;
	logic                             ray_stall;
	rti_pkg::coord_t                  origin_x, origin_y, origin_z;
	rti_pkg::coord_t                  direction_x, direction_y, direction_z;
	logic                             result_valid;
	logic                             result_stall;
	logic                             hit;
	logic [rti_pkg::DIST_BITS-1:0]    distance;
	logic [rti_pkg::BARY_BITS-1:0]    bary_u, bary_v;
	rti_pkg::coord_t                  point_x, point_y, point_z;

	// Local copy of the triangle and the threshold.
	logic [rti_pkg::VERT_BITS-1:0] vtx_a, vtx_b, vtx_c;
	logic [rti_pkg::EPS_BITS-1:0]  eps;

	ray_t   pending_rays[$];
	isect_t expected_hits[$];
	ray_t   cur_ray;
	int     send_gap, recv_hold;
	bit     quiet;
	int     errors, n_results, n_hits;

	ray_triangle_intersect uut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rti_pkg::coord_t sat_coord(input longint x);
		if (x > 524287) return rti_pkg::coord_t'(524287);
		if (x < -524288) return rti_pkg::coord_t'(-524288);
		return rti_pkg::coord_t'(x);
	endfunction

	function automatic longint frac_quot(input longint n, input longint den, input longint lim);
		longint qq, rr;
		qq = n / den;
		rr = n % den;
		if (qq > (lim >>> rti_pkg::FRAC_BITS)) return lim;
		repeat (rti_pkg::FRAC_BITS) begin
			qq = qq <<< 1;
			rr = rr <<< 1;
			if (rr >= den) begin
				rr = rr - den;
				qq = qq + 1;
			end
		end
		return (qq > lim) ? lim : qq;
	endfunction

	// Fixed-point Moller-Trumbore. Sets no_det when a zero determinant would
	// reach the division, which the stimulus then avoids.
	function automatic isect_t trace_ray(input ray_t r, output bit no_det);
		longint a[3], b[3], c[3], o[3], d[3];
		longint e1[3], e2[3], tv[3], p[3], q[3];
		longint det, nt, nu, nv, epsw, t, pt;
		isect_t res;
		res = '0;
		no_det = 1'b0;
		o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
		d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
		for (int k = 0; k < 3; k++) begin
			a[k] = rti_pkg::coord_t'(vtx_a[k*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
			b[k] = rti_pkg::coord_t'(vtx_b[k*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
			c[k] = rti_pkg::coord_t'(vtx_c[k*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
			e1[k] = b[k] - a[k];
			e2[k] = c[k] - a[k];
			tv[k] = o[k] - a[k];
		end
		p[0] = (d[1]*e2[2] - d[2]*e2[1]) >>> rti_pkg::FRAC_BITS;
		p[1] = (d[2]*e2[0] - d[0]*e2[2]) >>> rti_pkg::FRAC_BITS;
		p[2] = (d[0]*e2[1] - d[1]*e2[0]) >>> rti_pkg::FRAC_BITS;
		q[0] = (tv[1]*e1[2] - tv[2]*e1[1]) >>> rti_pkg::FRAC_BITS;
		q[1] = (tv[2]*e1[0] - tv[0]*e1[2]) >>> rti_pkg::FRAC_BITS;
		q[2] = (tv[0]*e1[1] - tv[1]*e1[0]) >>> rti_pkg::FRAC_BITS;
		det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
		epsw = longint'(eps) <<< rti_pkg::FRAC_BITS;
		if (det > -epsw && det < epsw) return res;
		nt = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
		nu = p[0]*tv[0] + p[1]*tv[1] + p[2]*tv[2];
		nv = q[0]*d[0] + q[1]*d[1] + q[2]*d[2];
		if (det < 0) begin
			det = -det;
			nt = -nt;
			nu = -nu;
			nv = -nv;
		end
		if (nu < 0 || nu > det || nv < 0 || nu + nv > det || nt <= 0) return res;
		if (det == 0) begin
			no_det = 1'b1;
			return res;
		end
		t = frac_quot(nt, det, DIST_MAX);
		if (t <= longint'(eps)) return res;
		res.hit = 1'b1;
		res.dist_v = t[rti_pkg::DIST_BITS-1:0];
		res.u = rti_pkg::BARY_BITS'(frac_quot(nu, det, ONE));
		res.v = rti_pkg::BARY_BITS'(frac_quot(nv, det, ONE));
		pt = o[0] + ((t * d[0]) >>> rti_pkg::FRAC_BITS);
		res.px = sat_coord(pt);
		pt = o[1] + ((t * d[1]) >>> rti_pkg::FRAC_BITS);
		res.py = sat_coord(pt);
		pt = o[2] + ((t * d[2]) >>> rti_pkg::FRAC_BITS);
		res.pz = sat_coord(pt);
		return res;
	endfunction

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 4);
	endfunction

	// Sender: a new ray goes out only when the current one has been taken.
	always @(posedge clk or negedge arst_n) begin
		bit     no_det;
		isect_t e;
		if (!arst_n) begin
			ray_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (ray_valid && !ray_stall) begin
				e = trace_ray(cur_ray, no_det);
				expected_hits.push_back(e);
			end
			if (!(ray_valid && ray_stall)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					ray_valid <= 1'b0;
				end else if (pending_rays.size() != 0) begin
					cur_ray = pending_rays.pop_front();
					origin_x <= cur_ray.ox;
					origin_y <= cur_ray.oy;
					origin_z <= cur_ray.oz;
					direction_x <= cur_ray.dx;
					direction_y <= cur_ray.dy;
					direction_z <= cur_ray.dz;
					ray_valid <= 1'b1;
					send_gap <= draw_wait();
				end else begin
					ray_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Receiver: compares each result transaction and draws its next stall.
	always @(posedge clk or negedge arst_n) begin
		isect_t e;
		int w;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_hold <= 0;
		end else if (result_valid && !result_stall) begin
			n_results++;
			if (expected_hits.size() == 0) begin
				$display("%0t: result with no ray outstanding", $time);
				errors++;
			end else begin
				e = expected_hits.pop_front();
				if (e.hit) n_hits++;
				check_field("hit", e.hit, hit);
				check_field("distance", e.dist_v, distance);
				check_field("bary_u", e.u, bary_u);
				check_field("bary_v", e.v, bary_v);
				check_field("point_x", e.px, point_x);
				check_field("point_y", e.py, point_y);
				check_field("point_z", e.pz, point_z);
			end
			w = draw_wait();
			recv_hold <= w;
			result_stall <= (w != 0);
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			result_stall <= (recv_hold > 1);
		end
	end

	task automatic write_reg(input rti_pkg::cfg_reg_t idx,
		input logic [rti_pkg::VERT_BITS-1:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			rti_pkg::REG_VERTEX_A: vtx_a = val;
			rti_pkg::REG_VERTEX_B: vtx_b = val;
			rti_pkg::REG_VERTEX_C: vtx_c = val;
			rti_pkg::REG_EPSILON:  eps = val[rti_pkg::EPS_BITS-1:0];
		endcase
	endtask

	task automatic drain();
		while (pending_rays.size() != 0 || ray_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [rti_pkg::VERT_BITS-1:0] pack_vtx(input longint x,
		input longint y, input longint z);
		return {rti_pkg::coord_t'(z), rti_pkg::coord_t'(y), rti_pkg::coord_t'(x)};
	endfunction

	function automatic ray_t mk_ray(input longint ox, input longint oy, input longint oz,
		input longint dx, input longint dy, input longint dz);
		ray_t r;
		r.ox = rti_pkg::coord_t'(ox); r.oy = rti_pkg::coord_t'(oy);
		r.oz = rti_pkg::coord_t'(oz);
		r.dx = rti_pkg::coord_t'(dx); r.dy = rti_pkg::coord_t'(dy);
		r.dz = rti_pkg::coord_t'(dz);
		return r;
	endfunction

	function automatic longint spread(input int range_v);
		return longint'($urandom_range(0, 2 * range_v)) - range_v;
	endfunction

	// Mostly rays aimed at a point of the triangle (in front, behind, or just
	// off it), the rest full-range noise.
	function automatic ray_t random_ray();
		longint a[3], e1[3], e2[3], pt[3], o[3], d[3];
		int u, v, kind, sh;
		kind = $urandom_range(0, 99);
		if (kind < 20)
			return ray_t'({$urandom, $urandom, $urandom, $urandom});
		u = $urandom_range(0, 4096);
		v = $urandom_range(0, 4096 - u);
		if (kind < 35) begin
			u = $urandom_range(0, 6000);
			v = $urandom_range(0, 6000);
		end
		sh = $urandom_range(0, 4);
		for (int k = 0; k < 3; k++) begin
			a[k] = rti_pkg::coord_t'(vtx_a[k*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
			e1[k] = longint'(rti_pkg::coord_t'(
				vtx_b[k*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS])) - a[k];
			e2[k] = longint'(rti_pkg::coord_t'(
				vtx_c[k*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS])) - a[k];
			pt[k] = a[k] + ((u * e1[k] + v * e2[k]) >>> rti_pkg::FRAC_BITS);
			o[k] = sat_coord(pt[k] + spread(1 << ($urandom_range(10, 18))));
			d[k] = (pt[k] - o[k]) >>> sh;
			if (kind >= 90) d[k] = -d[k];
		end
		return mk_ray(o[0], o[1], o[2], sat_coord(d[0]), sat_coord(d[1]), sat_coord(d[2]));
	endfunction

	initial begin
		ray_t r;
		bit no_det;
		isect_t dummy;
		int eps_pick[5];
		int span;
		logic [rti_pkg::EPS_BITS-1:0] eps_val;
		eps_pick = '{0, 4095, 1, -1, -1};
		cfg_write_en = 1'b0;
		cfg_index = rti_pkg::REG_VERTEX_A;
		cfg_data = '0;
		origin_x = '0; origin_y = '0; origin_z = '0;
		direction_x = '0; direction_y = '0; direction_z = '0;
		vtx_a = '0; vtx_b = '0; vtx_c = '0;
		eps = 1;
		quiet = 1'b0;
		errors = 0; n_results = 0; n_hits = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset triangle is a point, so every ray is degenerate.
		pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0));
		pending_rays.push_back(mk_ray(524287, 524287, 524287, 524287, 524287, 524287));
		pending_rays.push_back(mk_ray(-524288, -524288, -524288, -524288, -524288, -524288));
		drain();

		// Right triangle in the z=0 plane with 4.0 legs, rays mostly down -z.
		write_reg(rti_pkg::REG_VERTEX_A, pack_vtx(0, 0, 0));
		write_reg(rti_pkg::REG_VERTEX_B, pack_vtx(16384, 0, 0));
		write_reg(rti_pkg::REG_VERTEX_C, pack_vtx(0, 16384, 0));
		write_reg(rti_pkg::REG_EPSILON, {48'hABCDE_F0123_45, 12'd1});
		@(posedge clk);
		cfg_write_en <= 1'b0;
		pending_rays.push_back(mk_ray(4096, 4096, 4096, 0, 0, -4096));
		pending_rays.push_back(mk_ray(4096, 4096, 4096, 0, 0, 4096));
		pending_rays.push_back(mk_ray(20000, 1000, 4096, 0, 0, -4096));
		pending_rays.push_back(mk_ray(1000, 20000, 4096, 0, 0, -4096));
		pending_rays.push_back(mk_ray(12000, 12000, 4096, 0, 0, -4096));
		pending_rays.push_back(mk_ray(4096, 4096, 4096, 4096, 0, 0));
		pending_rays.push_back(mk_ray(4096, 4096, 1, 0, 0, -4096));
		pending_rays.push_back(mk_ray(4096, 4096, 524287, 0, 0, -1));
		pending_rays.push_back(mk_ray(0, 0, 4096, 0, 0, -4096));
		pending_rays.push_back(mk_ray(16384, 0, 4096, 0, 0, -4096));
		pending_rays.push_back(mk_ray(0, 16384, -4096, 0, 0, 4096));
		pending_rays.push_back(mk_ray(4096, 4096, 524287, 524287, 524287, -524288));
		pending_rays.push_back(mk_ray(-524288, -524288, 4096, 524287, 524287, -4096));
		pending_rays.push_back(mk_ray(524287, 524287, -524288, -524288, -524288, 524287));
		pending_rays.push_back(mk_ray(4096, 4096, 4096, -524288, -524288, -524288));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			span = (ph == 1) ? 19 : $urandom_range(14, 18);
			if (ph == 1) begin
				// Extreme vertices use the full coordinate range.
				write_reg(rti_pkg::REG_VERTEX_A, pack_vtx(-524288, -524288, -524288));
				write_reg(rti_pkg::REG_VERTEX_B, pack_vtx(524287, -524288, 524287));
				write_reg(rti_pkg::REG_VERTEX_C, pack_vtx(-524288, 524287, 524287));
			end else begin
				write_reg(rti_pkg::REG_VERTEX_A, pack_vtx(spread(1 << span),
					spread(1 << span), spread(1 << span)));
				write_reg(rti_pkg::REG_VERTEX_B, pack_vtx(spread(1 << span),
					spread(1 << span), spread(1 << span)));
				write_reg(rti_pkg::REG_VERTEX_C, pack_vtx(spread(1 << span),
					spread(1 << span), spread(1 << span)));
			end
			// Random bits above the threshold field must be ignored.
			eps_val = (eps_pick[ph] < 0) ? rti_pkg::EPS_BITS'($urandom_range(0, 64)) :
				rti_pkg::EPS_BITS'(eps_pick[ph]);
			write_reg(rti_pkg::REG_EPSILON,
				(rti_pkg::VERT_BITS'({$urandom, $urandom}) &
				~rti_pkg::VERT_BITS'(12'hFFF)) | rti_pkg::VERT_BITS'(eps_val));
			@(posedge clk);
			cfg_write_en <= 1'b0;
			quiet = (ph == 3);
			for (int i = 0; i < 386; i++) begin
				do begin
					r = random_ray();
					dummy = trace_ray(r, no_det);
				end while (no_det);
				pending_rays.push_back(r);
			end
			drain();
		end

		$display("Ran %0d rays over seven triangle settings and thresholds 0 to 4095;",
			n_results);
		$display("%0d hits, the rest degenerate, outside, behind or too near misses.", n_hits);
		if (errors == 0 && expected_hits.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timeout waiting for results.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
